// ===== rtl/core/julia_escape_time_pixel_defines.svh =====
// Assertion macros for the Julia escape-time pixel block.
// Included by the top level; no other dependencies.
`ifndef JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define JULIA_ESCAPE_TIME_PIXEL_DEFINES_SVH
`ifndef SYNTH
`define JETP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define JETP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define JETP_ASSERT(lbl, clk, rst_n, prop, msg)
`define JETP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/jetp_pkg.sv =====
// Shared constants, register indexes and control structs of the Julia
// escape-time pixel block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jetp_pkg;

  localparam int WordW            = 32;
  localparam int FracBits         = 28;
  localparam int DimW             = 13;
  localparam int LimitW           = 10;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 32;
  localparam int CoordBitsDefault = 12;

  localparam logic [CfgIdxW-1:0] RegImageWidth     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIterationLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCReal          = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCImag          = 3'd4;

  localparam logic [DimW-1:0]          RstImageWidth     = 13'd1024;
  localparam logic [DimW-1:0]          RstImageHeight    = 13'd512;
  localparam logic [LimitW-1:0]        RstIterationLimit = 10'd300;
  localparam logic signed [WordW-1:0]  RstCReal          = -32'sd212064829;
  localparam logic signed [WordW-1:0]  RstCImag          = 32'sd40265318;

  // Window spans and half spans, rounded half up at FracBits fraction bits
  localparam logic [63:0] SpanX = ((64'd32 << FracBits) + 64'd5) / 64'd10;
  localparam logic [63:0] SpanY = ((64'd18 << FracBits) + 64'd5) / 64'd10;
  localparam int          SpanW = $clog2(SpanX + 64'd1);
  localparam logic [WordW-1:0] HalfX = WordW'(((64'd16 << FracBits) + 64'd5) / 64'd10);
  localparam logic [WordW-1:0] HalfY = WordW'(((64'd9 << FracBits) + 64'd5) / 64'd10);

  typedef struct packed {
    logic accept;
    logic load_x;
    logic load_y;
    logic div_step;
    logic store_re;
    logic store_im;
    logic iter_mul;
    logic iter_upd;
  } jetp_cmd_t;

  typedef struct packed {
    logic bad_coord;
    logic div_done;
    logic left_zero;
    logic escape;
  } jetp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/jetp_cfg_regs.sv =====
// Configuration registers: image size, iteration budget and Julia constant.
// Depends on jetp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jetp_cfg_regs import jetp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output logic [DimW-1:0]           image_width_o,
  output logic [DimW-1:0]           image_height_o,
  output logic [LimitW-1:0]         iteration_limit_o,
  output logic signed [WordW-1:0]   c_real_o,
  output logic signed [WordW-1:0]   c_imag_o
);

  logic [DimW-1:0]         width_q;
  logic [DimW-1:0]         height_q;
  logic [LimitW-1:0]       limit_q;
  logic signed [WordW-1:0] c_real_q;
  logic signed [WordW-1:0] c_imag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RstImageWidth;
      height_q <= RstImageHeight;
      limit_q  <= RstIterationLimit;
      c_real_q <= RstCReal;
      c_imag_q <= RstCImag;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegImageWidth:     width_q  <= cfg_data_i[DimW-1:0];
        RegImageHeight:    height_q <= cfg_data_i[DimW-1:0];
        RegIterationLimit: limit_q  <= cfg_data_i[LimitW-1:0];
        RegCReal:          c_real_q <= cfg_data_i[WordW-1:0];
        RegCImag:          c_imag_q <= cfg_data_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  assign image_width_o     = width_q;
  assign image_height_o    = height_q;
  assign iteration_limit_o = limit_q;
  assign c_real_o          = c_real_q;
  assign c_imag_o          = c_imag_q;

endmodule

`default_nettype wire

// ===== rtl/core/jetp_ctrl.sv =====
// Controller: sequences coordinate division and the z*z+c iteration.
// Depends on jetp_pkg; drives jetp_datapath through jetp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module jetp_ctrl import jetp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       done_o,
  input  jetp_stat_t stat_i,
  output jetp_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StLoadX = 3'd1;
  localparam logic [2:0] StDivX  = 3'd2;
  localparam logic [2:0] StLoadY = 3'd3;
  localparam logic [2:0] StDivY  = 3'd4;
  localparam logic [2:0] StMul   = 3'd5;
  localparam logic [2:0] StUpd   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.bad_coord ? StDone : StLoadX;
        end
      end
      StLoadX: begin
        cmd_o.load_x = 1'b1;
        state_d      = StDivX;
      end
      StDivX: begin
        if (stat_i.div_done) begin
          cmd_o.store_re = 1'b1;
          state_d        = StLoadY;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StLoadY: begin
        cmd_o.load_y = 1'b1;
        state_d      = StDivY;
      end
      StDivY: begin
        if (stat_i.div_done) begin
          cmd_o.store_im = 1'b1;
          state_d        = StMul;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StMul: begin
        if (stat_i.left_zero) begin
          state_d = StDone;
        end else begin
          cmd_o.iter_mul = 1'b1;
          state_d        = StUpd;
        end
      end
      StUpd: begin
        if (stat_i.escape) begin
          state_d = StDone;
        end else begin
          cmd_o.iter_upd = 1'b1;
          state_d        = StMul;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

`default_nettype wire

// ===== rtl/core/jetp_datapath.sv =====
// Datapath: coordinate scaling through a restoring divider, and the
// fixed-point z*z+c iteration with escape test. Depends on jetp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jetp_datapath import jetp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                    clk_i,
  input  jetp_cmd_t               cmd_i,
  output jetp_stat_t              stat_o,
  input  logic [COORD_BITS-1:0]   pixel_x_i,
  input  logic [COORD_BITS-1:0]   pixel_y_i,
  input  logic [DimW-1:0]         image_width_i,
  input  logic [DimW-1:0]         image_height_i,
  input  logic [LimitW-1:0]       iteration_limit_i,
  input  logic signed [WordW-1:0] c_real_i,
  input  logic signed [WordW-1:0] c_imag_i,
  output logic [LimitW-1:0]       left_o,
  output logic                    bad_o
);

  localparam int DivW   = COORD_BITS + SpanW;
  localparam int CntW   = $clog2(DivW + 1);
  localparam int CmpW   = (COORD_BITS > DimW) ? COORD_BITS : DimW;
  localparam int ProdW  = 2 * WordW;
  localparam int SumW   = ProdW - FracBits + 2;
  localparam int EscBit = 2 * FracBits + 2;

  function automatic logic signed [WordW-1:0] sat_word(input logic signed [SumW-1:0] v);
    logic fits;
    logic signed [WordW-1:0] r;
    fits = (&v[SumW-1:WordW-1]) || !(|v[SumW-1:WordW-1]);
    if (fits) begin
      r = v[WordW-1:0];
    end else if (v[SumW-1]) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end
    return r;
  endfunction

  logic [COORD_BITS-1:0]   px_q;
  logic [COORD_BITS-1:0]   py_q;
  logic [LimitW-1:0]       left_q;
  logic                    bad_q;
  logic [DimW-1:0]         den_q;
  logic [DimW:0]           rem_q;
  logic [DivW-1:0]         quo_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [WordW-1:0] re_q;
  logic signed [WordW-1:0] im_q;
  logic signed [ProdW-1:0] rr_q;
  logic signed [ProdW-1:0] ii_q;
  logic signed [ProdW-1:0] ri_q;

  logic                          bad_coord;
  logic [COORD_BITS-1:0]         sel_p;
  logic [SpanW-1:0]              sel_span;
  logic [DimW-1:0]               sel_den;
  logic [DivW-1:0]               num;
  logic [DimW:0]                 shifted;
  logic                          take;
  logic [DimW:0]                 diff;
  logic [WordW-1:0]              coord;
  logic [ProdW-1:0]              mag;
  logic signed [ProdW-1:0]       dre;
  logic signed [ProdW-FracBits-1:0] sre;
  logic signed [ProdW-FracBits:0]   sim;
  logic signed [SumW-1:0]        sum_re;
  logic signed [SumW-1:0]        sum_im;

  assign bad_coord = (CmpW'(pixel_x_i) >= CmpW'(image_width_i)) ||
                     (CmpW'(pixel_y_i) >= CmpW'(image_height_i));

  assign sel_p    = cmd_i.load_x ? px_q : py_q;
  assign sel_span = cmd_i.load_x ? SpanW'(SpanX) : SpanW'(SpanY);
  assign sel_den  = cmd_i.load_x ? image_width_i : image_height_i;
  assign num      = DivW'(sel_p) * DivW'(sel_span);

  assign shifted = {rem_q[DimW-1:0], quo_q[DivW-1]};
  assign take    = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};
  assign coord   = {{(WordW-SpanW){1'b0}}, quo_q[SpanW-1:0]};

  assign mag    = $unsigned(rr_q) + $unsigned(ii_q);
  assign dre    = rr_q - ii_q;
  assign sre    = dre[ProdW-1:FracBits];
  assign sim    = ri_q[ProdW-1:FracBits-1];
  assign sum_re = SumW'(sre) + SumW'(c_real_i);
  assign sum_im = SumW'(sim) + SumW'(c_imag_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      px_q   <= pixel_x_i;
      py_q   <= pixel_y_i;
      bad_q  <= bad_coord;
      left_q <= bad_coord ? '0 : iteration_limit_i;
    end
    if (cmd_i.load_x || cmd_i.load_y) begin
      quo_q <= num;
      rem_q <= '0;
      den_q <= sel_den;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? diff : shifted;
      quo_q <= {quo_q[DivW-2:0], take};
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.store_re) begin
      re_q <= coord - HalfX;
    end
    if (cmd_i.store_im) begin
      im_q <= coord - HalfY;
    end
    if (cmd_i.iter_mul) begin
      rr_q <= re_q * re_q;
      ii_q <= im_q * im_q;
      ri_q <= re_q * im_q;
    end
    if (cmd_i.iter_upd) begin
      re_q   <= sat_word(sum_re);
      im_q   <= sat_word(sum_im);
      left_q <= left_q - LimitW'(1);
    end
  end

  assign stat_o.bad_coord = bad_coord;
  assign stat_o.div_done  = (cnt_q == CntW'(DivW));
  assign stat_o.left_zero = (left_q == '0);
  assign stat_o.escape    = |mag[ProdW-1:EscBit];

  assign left_o = left_q;
  assign bad_o  = bad_q;

endmodule

`default_nettype wire

// ===== rtl/core/julia_escape_time_pixel.sv =====
// Top level of the Julia escape-time pixel block.
// Depends on jetp_pkg, jetp_cfg_regs, jetp_ctrl, jetp_datapath and
// julia_escape_time_pixel_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "julia_escape_time_pixel_defines.svh"

// Usage:
//   Input: drive pixel_x_i/pixel_y_i and raise start; the item is taken at
//   an edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Output: done_o is high for one cycle with iterations_left_o,
//   never_escaped_o and bad_coordinate_o valid; the receiver must take it.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; write
//   only while busy is low. cfg_ready_o is always high.
//   Timing: a pixel outside the image shows its result in the cycle after
//   accept. Otherwise each coordinate goes through a one-bit-per-cycle
//   divider, then every iteration runs a multiply step and then an
//   update step. The next item can be taken in the cycle after done_o.
//   Reset: returns to idle and loads the default configuration; an item in
//   flight is dropped.

module julia_escape_time_pixel import jetp_pkg::*; #(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  output logic                  done_o,
  output logic [LimitW-1:0]     iterations_left_o,
  output logic                  never_escaped_o,
  output logic                  bad_coordinate_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  logic [DimW-1:0]         image_width;
  logic [DimW-1:0]         image_height;
  logic [LimitW-1:0]       iteration_limit;
  logic signed [WordW-1:0] c_real;
  logic signed [WordW-1:0] c_imag;
  jetp_cmd_t               cmd;
  jetp_stat_t              stat;
  logic [LimitW-1:0]       left;
  logic                    bad;

  jetp_cfg_regs u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .image_width_o     (image_width),
    .image_height_o    (image_height),
    .iteration_limit_o (iteration_limit),
    .c_real_o          (c_real),
    .c_imag_o          (c_imag)
  );

  jetp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  jetp_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .image_width_i     (image_width),
    .image_height_i    (image_height),
    .iteration_limit_i (iteration_limit),
    .c_real_i          (c_real),
    .c_imag_i          (c_imag),
    .left_o            (left),
    .bad_o             (bad)
  );

  assign iterations_left_o = left;
  assign never_escaped_o   = (left == '0) && !bad;
  assign bad_coordinate_o  = bad;

  `JETP_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy, "busy not raised after accept")
  `JETP_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy, "result shown while idle")
  `JETP_ASSERT_NEVER(a_done_flags, clk_i, rst_ni, done_o && never_escaped_o && bad_coordinate_o, "bad coordinate flagged as inside")
  `JETP_ASSERT(a_bad_zero, clk_i, rst_ni, done_o && bad_coordinate_o |-> iterations_left_o == '0, "bad coordinate with nonzero count")
  `JETP_ASSERT(a_left_limit, clk_i, rst_ni, done_o |-> iterations_left_o <= iteration_limit, "count above iteration limit")

endmodule

`default_nettype wire
